[design/alrg_pkg.sv]
// Shared types, constants and helper functions for the additive lagged
// random generator. No dependencies; used by every design file but alrg_ram.
package alrg_pkg;

  localparam int RING_DEPTH = 32;
  localparam int LAG_OFFSET = 3;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WORD_W     = 32;
  localparam int RES_W      = 31;
  localparam int CNT_W      = 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam word_t LCG_MUL      = 32'd1103515245;
  localparam word_t LCG_ADD      = 32'd12345;
  localparam cnt_t  DISCARD_MASK = 8'hff;

  localparam idx_t LAG_INIT = IDX_W'(LAG_OFFSET % RING_DEPTH);
  localparam idx_t LAST_IDX = IDX_W'(RING_DEPTH - 1);

  localparam word_t INIT_TABLE [32] = '{
    32'h6fdb9cb7, 32'h9de8dc3d, 32'h093bf9e4, 32'h47528c2b, 32'hfc263867, 32'h53cbf1bf,
    32'h13618c92, 32'h9e0f31b1, 32'hcd651ab0, 32'h2b52a7e5, 32'h2ccdd9bf, 32'h30052e2e,
    32'hb278be81, 32'hd634a58b, 32'h0a33d2c1, 32'hfd42f052, 32'hcb2f06f8, 32'ha57bb730,
    32'h4ca963ac, 32'h84bf5532, 32'hd67ab9e6, 32'h6e2d017b, 32'h1e17cd99, 32'h5891173a,
    32'h39384a29, 32'he0a0282e, 32'h2e5512fc, 32'h3093f269, 32'h3a6983e6, 32'h6b9fdaf3,
    32'h38b6bbd1, 32'hb5e23046
  };

  // Reset contents of a ring entry: the constant table repeats every 32 words.
  function automatic word_t init_word(idx_t idx);
    logic [4:0] pos;
    pos = 5'(idx);
    return INIT_TABLE[pos];
  endfunction

  function automatic idx_t next_idx(idx_t idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RDA,
    S_RDB,
    S_CALC
  } seq_state_t;

  // Why a draw runs: a user request or one step of the discard loops.
  typedef enum logic [1:0] {
    P_USER,
    P_L1,
    P_L2_TEST,
    P_L2_BODY
  } draw_use_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
  } ring_req_t;

  typedef struct packed {
    logic             valid;
    logic [RES_W-1:0] value;
  } draw_res_t;

endpackage

[design/alrg_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No package dependencies.
module alrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/alrg_ring.sv]
// Ring word storage: RAM instance plus per-entry valid bits so that an
// unwritten entry reads as its reset constant. Uses alrg_pkg and alrg_ram.
module alrg_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  alrg_pkg::ring_req_t req,
  output alrg_pkg::word_t     rd_data
);

  logic [alrg_pkg::RING_DEPTH-1:0] valid_r;
  logic                            rd_hit_r;
  alrg_pkg::idx_t                  rd_addr_r;
  alrg_pkg::word_t                 ram_q;

  alrg_ram #(
    .WIDTH(alrg_pkg::WORD_W),
    .DEPTH(alrg_pkg::RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_addr_r <= req.rd_addr;
    end
  end

  // Fall back to the reset constant until the entry has been written.
  assign rd_data = rd_hit_r ? ram_q : alrg_pkg::init_word(rd_addr_r);

endmodule

[design/alrg_seq.sv]
// Draw and reseed sequencer: ring indices, read-modify-write of ring words,
// LCG fill walk and discard loops. Uses alrg_pkg; drives alrg_ring requests.
module alrg_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                start_kind,
  input  alrg_pkg::word_t     start_seed,
  output logic                idle,
  input  logic                res_ready,
  output alrg_pkg::draw_res_t res,
  output alrg_pkg::ring_req_t ring_req,
  input  alrg_pkg::word_t     ring_rd_data
);

  alrg_pkg::seq_state_t state_r, state_nxt;
  alrg_pkg::draw_use_t  use_r, use_nxt;
  alrg_pkg::idx_t       first_r, first_nxt;
  alrg_pkg::idx_t       second_r, second_nxt;
  alrg_pkg::idx_t       fill_r, fill_nxt;
  alrg_pkg::cnt_t       n_r, n_nxt;
  alrg_pkg::word_t      x_r, x_nxt;
  alrg_pkg::word_t      a_r, a_nxt;

  alrg_pkg::word_t      a_use;
  alrg_pkg::word_t      sum;
  alrg_pkg::word_t      x_step;
  alrg_pkg::cnt_t       limit;
  logic                 stop;

  // Negate word a only when both words are negative.
  assign a_use  = (a_r[31] && ring_rd_data[31]) ? (~a_r + 32'd1) : a_r;
  assign sum    = a_use + ring_rd_data;
  assign x_step = x_r * alrg_pkg::LCG_MUL + alrg_pkg::LCG_ADD;
  assign limit  = (sum[alrg_pkg::CNT_W:1] ^ x_r[alrg_pkg::CNT_W-1:0]) & alrg_pkg::DISCARD_MASK;
  assign stop   = (n_r >= limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= alrg_pkg::S_IDLE;
      use_r    <= alrg_pkg::P_USER;
      first_r  <= '0;
      second_r <= alrg_pkg::LAG_INIT;
      fill_r   <= '0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      use_r    <= use_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      fill_r   <= fill_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    a_r <= a_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    use_nxt    = use_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    fill_nxt   = fill_r;
    n_nxt      = n_r;
    x_nxt      = x_r;
    a_nxt      = a_r;
    ring_req   = '0;
    res.valid  = 1'b0;
    res.value  = sum[31:1];
    idle       = 1'b0;

    case (state_r)
      alrg_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          if (start_kind) begin
            x_nxt     = start_seed;
            fill_nxt  = '0;
            state_nxt = alrg_pkg::S_FILL;
          end else begin
            use_nxt   = alrg_pkg::P_USER;
            state_nxt = alrg_pkg::S_RDA;
          end
        end
      end
      alrg_pkg::S_FILL: begin
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = fill_r;
        ring_req.wr_data = x_step;
        x_nxt            = x_step;
        fill_nxt         = alrg_pkg::next_idx(fill_r);
        if (fill_r == alrg_pkg::LAST_IDX) begin
          first_nxt  = '0;
          second_nxt = alrg_pkg::LAG_INIT;
          use_nxt    = alrg_pkg::P_L1;
          n_nxt      = '0;
          state_nxt  = alrg_pkg::S_RDA;
        end
      end
      alrg_pkg::S_RDA: begin
        ring_req.rd_en   = 1'b1;
        ring_req.rd_addr = first_r;
        state_nxt        = alrg_pkg::S_RDB;
      end
      alrg_pkg::S_RDB: begin
        ring_req.rd_en   = 1'b1;
        ring_req.rd_addr = second_r;
        a_nxt            = ring_rd_data;
        state_nxt        = alrg_pkg::S_CALC;
      end
      alrg_pkg::S_CALC: begin
        // Hold a user draw until the output register can take it.
        if (use_r != alrg_pkg::P_USER || res_ready) begin
          ring_req.wr_en   = 1'b1;
          ring_req.wr_addr = second_r;
          ring_req.wr_data = sum;
          first_nxt        = alrg_pkg::next_idx(first_r);
          second_nxt       = alrg_pkg::next_idx(second_r);
          case (use_r)
            alrg_pkg::P_USER: begin
              res.valid = 1'b1;
              state_nxt = alrg_pkg::S_IDLE;
            end
            alrg_pkg::P_L1: begin
              state_nxt = alrg_pkg::S_RDA;
              if (stop) begin
                n_nxt   = '0;
                use_nxt = alrg_pkg::P_L2_TEST;
              end else begin
                n_nxt = n_r + 1'b1;
              end
            end
            alrg_pkg::P_L2_TEST: begin
              if (stop) begin
                state_nxt = alrg_pkg::S_IDLE;
              end else begin
                use_nxt   = alrg_pkg::P_L2_BODY;
                state_nxt = alrg_pkg::S_RDA;
              end
            end
            alrg_pkg::P_L2_BODY: begin
              n_nxt     = n_r + 1'b1;
              use_nxt   = alrg_pkg::P_L2_TEST;
              state_nxt = alrg_pkg::S_RDA;
            end
            default: begin
              state_nxt = alrg_pkg::S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = alrg_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_req.rd_en && ring_req.wr_en))
    else $error("ring read and write in the same cycle");

  a_lag_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(second_r) - int'(first_r) == int'(alrg_pkg::LAG_INIT)) ||
    (int'(second_r) - int'(first_r) == int'(alrg_pkg::LAG_INIT) - alrg_pkg::RING_DEPTH))
    else $error("ring indices lost their lag");

  a_fill_to_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alrg_pkg::S_FILL && fill_r == alrg_pkg::LAST_IDX) |=>
    (state_r == alrg_pkg::S_RDA && use_r == alrg_pkg::P_L1 && first_r == '0))
    else $error("fill walk did not start the discard loop");

  a_res_only_user: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == alrg_pkg::S_CALC && use_r == alrg_pkg::P_USER && res_ready))
    else $error("result raised outside a user draw");
`endif

endmodule

[design/additive_lagged_random_generator_unit.sv]
// Additive lagged random generator, top level.
// Input channel (in_valid / in_stall): one request carries in_kind and
// in_seed_value. in_kind = 0 draws the next number; in_kind = 1 reseeds
// from in_seed_value and returns nothing.
// Result channel (out_valid / out_stall): one out_random_value per draw.
// A draw reads word a, reads word b, then adds and writes back (states
// S_RDA, S_RDB and S_CALC), using the one read port of the ring RAM; the
// result shows on out_valid in the cycle after the add, and the next
// request can be taken in that same cycle. No request is taken while a
// draw is in progress. A reseed walks the 32-entry ring with the LCG
// multiplier, one word a cycle, then runs the discard draws, their number
// depending on the seed. in_stall is high meanwhile.
// Reset (synchronous, rst_n low) returns the ring to its constant table
// and the indices to 0 and 3 at once; the ring is usable immediately.
// When the receiver stalls, the result waits in the output register and
// the block still takes the next request; a further draw holds in its
// last step until the output register frees up.
// Depends on alrg_pkg, alrg_seq and alrg_ring.
module additive_lagged_random_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic signed [31:0]  in_seed_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [30:0]         out_random_value
);

  alrg_pkg::ring_req_t ring_req;
  alrg_pkg::word_t     ring_rd_data;
  alrg_pkg::draw_res_t res;
  logic                idle;
  logic                start;
  logic                res_ready;
  logic                out_valid_r;
  logic [30:0]         out_value_r;

  assign in_stall  = !idle;
  assign start     = in_valid && !in_stall;
  assign res_ready = !out_valid_r || !out_stall;

  alrg_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .start_kind   (in_kind),
    .start_seed   (alrg_pkg::word_t'(in_seed_value)),
    .idle         (idle),
    .res_ready    (res_ready),
    .res          (res),
    .ring_req     (ring_req),
    .ring_rd_data (ring_rd_data)
  );

  alrg_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r <= res.value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule
